[src/pslm_pkg.sv]
// Package with the shared types and constants of the packet sequence and latency monitor.
package pslm_pkg;

  // Microseconds in one second, used to turn a timestamp into a flat count.
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  // A time or latency in microseconds.
  typedef logic [51:0] lat_t;

  // Classification of a received packet.
  typedef enum logic [1:0] {
    CLS_FIRST     = 2'd0,
    CLS_DUP       = 2'd1,
    CLS_UNORDERED = 2'd2,
    CLS_INORDER   = 2'd3
  } pkt_class_e;

  // One word held in the queue between the front and back parts.
  typedef struct packed {
    logic [31:0] seq_num;
    lat_t        latency;
  } queue_item_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/pslm_in_if.sv]
// Input channel: one received reply packet per word.
interface pslm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seq_num;
  logic [31:0] sent_sec;
  logic [19:0] sent_usec;
  logic [31:0] now_sec;
  logic [19:0] now_usec;

  modport source (
    output valid, seq_num, sent_sec, sent_usec, now_sec, now_usec,
    input  ready
  );
  modport sink (
    input  valid, seq_num, sent_sec, sent_usec, now_sec, now_usec,
    output ready
  );
endinterface

[src/pslm_out_if.sv]
// Output channel: the classification and statistics after each packet.
interface pslm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  pkt_class;
  logic [51:0] latency_us;
  logic [31:0] recv_count;
  logic [31:0] dup_count;
  logic [31:0] unordered_count;
  logic [51:0] min_latency_us;
  logic [51:0] max_latency_us;
  logic [31:0] highest_seq;

  modport source (
    output valid, pkt_class, latency_us, recv_count, dup_count, unordered_count,
           min_latency_us, max_latency_us, highest_seq,
    input  ready
  );
  modport sink (
    input  valid, pkt_class, latency_us, recv_count, dup_count, unordered_count,
           min_latency_us, max_latency_us, highest_seq,
    output ready
  );
endinterface

[src/pslm_front.sv]
// Front part: converts timestamps to microseconds and works out the latency.
module pslm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            seq_num_i,
  input  logic [31:0]            sent_sec_i,
  input  logic [19:0]            sent_usec_i,
  input  logic [31:0]            now_sec_i,
  input  logic [19:0]            now_usec_i,
  input  pslm_pkg::queue_stat_t  q_stat_i,
  output logic                   push_o,
  output pslm_pkg::queue_item_t  push_item_o
);

  logic          valid_q, valid_d;
  logic [31:0]   seq_q, seq_d;
  pslm_pkg::lat_t sent_us_q, sent_us_d;
  pslm_pkg::lat_t now_us_q, now_us_d;
  logic          load;

  // The stage takes a new word when it is empty or its word moves on.
  assign push_o     = valid_q && !q_stat_i.full;
  assign in_ready_o = !valid_q || !q_stat_i.full;
  assign load       = in_valid_i && in_ready_o;

  // Flat microsecond counts; the product of a 32-bit value and a 20-bit constant fits in 52 bits.
  always_comb begin
    seq_d     = seq_num_i;
    sent_us_d = 52'(sent_sec_i) * 52'(pslm_pkg::USEC_PER_SEC) + 52'(sent_usec_i);
    now_us_d  = 52'(now_sec_i) * 52'(pslm_pkg::USEC_PER_SEC) + 52'(now_usec_i);
    valid_d   = load ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_q     <= seq_d;
      sent_us_q <= sent_us_d;
      now_us_q  <= now_us_d;
    end
  end

  // Latency is zero when the reception time is not later than the send time.
  always_comb begin
    push_item_o.seq_num = seq_q;
    push_item_o.latency = (now_us_q > sent_us_q) ? (now_us_q - sent_us_q) : '0;
  end

endmodule

[src/pslm_fifo.sv]
// Short queue that decouples the front part from the back part.
module pslm_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pslm_pkg::queue_item_t  push_item_i,
  input  logic                   pop_i,
  output pslm_pkg::queue_item_t  pop_item_o,
  output pslm_pkg::queue_stat_t  stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pslm_pkg::queue_item_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FULL_CNT);
  assign stat_o.empty = (count_q == '0);

endmodule

[src/pslm_back.sv]
// Back part: classifies each packet, updates the statistics and holds the result word.
module pslm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pslm_pkg::queue_stat_t  q_stat_i,
  input  pslm_pkg::queue_item_t  pop_item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             pkt_class_o,
  output logic [51:0]            latency_us_o,
  output logic [31:0]            recv_count_o,
  output logic [31:0]            dup_count_o,
  output logic [31:0]            unordered_count_o,
  output logic [51:0]            min_latency_us_o,
  output logic [51:0]            max_latency_us_o,
  output logic [31:0]            highest_seq_o
);

  logic                 out_valid_q, out_valid_d;
  logic [31:0]          last_seq_q, last_seq_d;
  logic [31:0]          recv_q, recv_d;
  logic [31:0]          dup_q, dup_d;
  logic [31:0]          unord_q, unord_d;
  pslm_pkg::lat_t       min_q, min_d;
  pslm_pkg::lat_t       max_q, max_d;
  pslm_pkg::pkt_class_e cls_q, cls_d;
  pslm_pkg::lat_t       lat_q;

  // A word leaves the queue when the result register is free or being emptied.
  assign pop_o       = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Classification and statistics update for the word at the head of the queue.
  always_comb begin
    last_seq_d = last_seq_q;
    recv_d     = recv_q;
    dup_d      = dup_q;
    unord_d    = unord_q;
    min_d      = min_q;
    max_d      = max_q;
    if (last_seq_q == '0) begin
      cls_d      = pslm_pkg::CLS_FIRST;
      last_seq_d = pop_item_i.seq_num;
      recv_d     = recv_q + 32'd1;
      min_d      = pop_item_i.latency;
      max_d      = pop_item_i.latency;
    end else begin
      priority if (pop_item_i.seq_num == last_seq_q) begin
        cls_d = pslm_pkg::CLS_DUP;
        dup_d = dup_q + 32'd1;
      end else if (pop_item_i.seq_num < last_seq_q) begin
        cls_d   = pslm_pkg::CLS_UNORDERED;
        unord_d = unord_q + 32'd1;
        recv_d  = recv_q + 32'd1;
      end else begin
        cls_d      = pslm_pkg::CLS_INORDER;
        last_seq_d = pop_item_i.seq_num;
        recv_d     = recv_q + 32'd1;
      end
      if (pop_item_i.latency < min_q) begin
        min_d = pop_item_i.latency;
      end
      if (pop_item_i.latency > max_q) begin
        max_d = pop_item_i.latency;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_seq_q  <= '0;
      recv_q      <= '0;
      dup_q       <= '0;
      unord_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        last_seq_q <= last_seq_d;
        recv_q     <= recv_d;
        dup_q      <= dup_d;
        unord_q    <= unord_d;
        min_q      <= min_d;
        max_q      <= max_d;
      end
    end
  end

  // Per-word result fields; the statistics registers double as the result.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q <= cls_d;
      lat_q <= pop_item_i.latency;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pkt_class_o       = cls_q;
  assign latency_us_o      = lat_q;
  assign recv_count_o      = recv_q;
  assign dup_count_o       = dup_q;
  assign unordered_count_o = unord_q;
  assign min_latency_us_o  = min_q;
  assign max_latency_us_o  = max_q;
  assign highest_seq_o     = last_seq_q;

endmodule

[src/packet_seq_latency_monitor_core.sv]
// Packet sequence and latency monitor: one result word for each received packet.
// Path: an accepted word passes the front stage register, the queue and the result register in turn.
// Throughput: one word per cycle while the output is ready; the front stage and the result register each pass one word
// a cycle, and the queue of QUEUE_DEPTH words absorbs output stalls.
// Reset: rst_ni clears the sequence state, all counters and min/max latency to zero at once.
module packet_seq_latency_monitor_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pslm_in_if.sink    in_i,
  pslm_out_if.source out_o
);

  pslm_pkg::queue_stat_t q_stat;
  pslm_pkg::queue_item_t push_item;
  pslm_pkg::queue_item_t pop_item;
  logic                  push;
  logic                  pop;

  pslm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .seq_num_i   (in_i.seq_num),
    .sent_sec_i  (in_i.sent_sec),
    .sent_usec_i (in_i.sent_usec),
    .now_sec_i   (in_i.now_sec),
    .now_usec_i  (in_i.now_usec),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  pslm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  pslm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .pop_item_i        (pop_item),
    .pop_o             (pop),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .pkt_class_o       (out_o.pkt_class),
    .latency_us_o      (out_o.latency_us),
    .recv_count_o      (out_o.recv_count),
    .dup_count_o       (out_o.dup_count),
    .unordered_count_o (out_o.unordered_count),
    .min_latency_us_o  (out_o.min_latency_us),
    .max_latency_us_o  (out_o.max_latency_us),
    .highest_seq_o     (out_o.highest_seq)
  );

endmodule

[src/pslm_checker.sv]
// Checker on the output port of the monitor, and its binding to the top level.
module pslm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  pkt_class_i,
  input logic [51:0] latency_us_i,
  input logic [31:0] recv_count_i,
  input logic [51:0] min_latency_us_i,
  input logic [51:0] max_latency_us_i,
  input logic [31:0] highest_seq_i
);

  // A stalled word stays on the port with its receive count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(recv_count_i))
    else $error("Stalled output word changed or vanished.");

  // Every latency lies between the least and the greatest seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_latency_us_i <= latency_us_i) && (latency_us_i <= max_latency_us_i))
    else $error("Latency lies outside the min/max range.");

  // A first packet reloads both extremes with its own latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pkt_class_i == pslm_pkg::CLS_FIRST) |->
      (min_latency_us_i == latency_us_i) && (max_latency_us_i == latency_us_i))
    else $error("First packet did not reload min and max latency.");

  // An in-order packet always leaves a nonzero highest sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pkt_class_i == pslm_pkg::CLS_INORDER) |-> (highest_seq_i != '0))
    else $error("In-order packet left a zero highest sequence.");

endmodule

bind packet_seq_latency_monitor_core pslm_checker u_pslm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .pkt_class_i      (out_o.pkt_class),
  .latency_us_i     (out_o.latency_us),
  .recv_count_i     (out_o.recv_count),
  .min_latency_us_i (out_o.min_latency_us),
  .max_latency_us_i (out_o.max_latency_us),
  .highest_seq_i    (out_o.highest_seq)
);

[verif/packet_seq_latency_monitor_core_tb.sv]
// Self-checking testbench for the packet sequence and latency monitor core.
`timescale 1ns / 100ps

module packet_seq_latency_monitor_core_tb;

  localparam int unsigned CLK_PERIOD      = 12;
  localparam int unsigned RESET_CYCLES    = 4;
  localparam int unsigned RANDOM_WORDS    = 1250;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_AT     = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned TAIL_CYCLES     = 20;

  // One received reply packet, or a marker that holds the sender until all results are back.
  typedef struct {
    logic        drain;
    logic [31:0] seq_num;
    logic [31:0] sent_sec;
    logic [19:0] sent_usec;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } packet_t;

  // Classification and statistics expected after one packet.
  typedef struct {
    pslm_pkg::pkt_class_e cls;
    pslm_pkg::lat_t       latency;
    logic [31:0]          recv;
    logic [31:0]          dup;
    logic [31:0]          unord;
    pslm_pkg::lat_t       lat_min;
    pslm_pkg::lat_t       lat_max;
    logic [31:0]          top_seq;
  } stats_t;

  logic clk_i;
  logic rst_ni;

  pslm_in_if  in_ch ();
  pslm_out_if out_ch ();

  packet_seq_latency_monitor_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  packet_t     pending_q[$];
  stats_t      stats_q[$];
  packet_t     cur_pkt;
  int unsigned idle_left;
  int unsigned stall_left;
  bit          hold_done;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_cycles;

  // Shadow copy of the sequence and latency statistics.
  logic [31:0]    seq_last;
  logic [31:0]    recv_total;
  logic [31:0]    dup_total;
  logic [31:0]    unord_total;
  pslm_pkg::lat_t lat_least;
  pslm_pkg::lat_t lat_greatest;

  // A timestamp flattened to microseconds; the microsecond part is used as given.
  function automatic pslm_pkg::lat_t flat_usec(logic [31:0] sec, logic [19:0] usec);
    longint unsigned t;
    t = 64'(sec) * 64'(pslm_pkg::USEC_PER_SEC) + 64'(usec);
    return t[51:0];
  endfunction

  // Classify one packet and advance the shadow statistics.
  function automatic stats_t classify_packet(packet_t p);
    pslm_pkg::lat_t sent;
    pslm_pkg::lat_t now;
    pslm_pkg::lat_t lat;
    stats_t         s;
    sent = flat_usec(p.sent_sec, p.sent_usec);
    now  = flat_usec(p.now_sec, p.now_usec);
    lat  = (now > sent) ? now - sent : '0;
    if (seq_last == 32'd0) begin
      // A first packet reloads min and max; sequence zero keeps the next one first as well.
      s.cls        = pslm_pkg::CLS_FIRST;
      seq_last     = p.seq_num;
      recv_total   = recv_total + 32'd1;
      lat_least    = lat;
      lat_greatest = lat;
    end else begin
      if (p.seq_num == seq_last) begin
        s.cls     = pslm_pkg::CLS_DUP;
        dup_total = dup_total + 32'd1;
      end else if (p.seq_num < seq_last) begin
        s.cls       = pslm_pkg::CLS_UNORDERED;
        unord_total = unord_total + 32'd1;
        recv_total  = recv_total + 32'd1;
      end else begin
        s.cls      = pslm_pkg::CLS_INORDER;
        seq_last   = p.seq_num;
        recv_total = recv_total + 32'd1;
      end
      if (lat < lat_least) lat_least = lat;
      if (lat > lat_greatest) lat_greatest = lat;
    end
    s.latency = lat;
    s.recv    = recv_total;
    s.dup     = dup_total;
    s.unord   = unord_total;
    s.lat_min = lat_least;
    s.lat_max = lat_greatest;
    s.top_seq = seq_last;
    return s;
  endfunction

  // Idle length: mostly none or short, a few long, and whole stretches without idling.
  function automatic int unsigned idle_len(int unsigned count);
    int unsigned r;
    if ((count / 150) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      n_errors++;
    end
  endtask

  task automatic add_pkt(logic [31:0] seq, logic [31:0] s_sec, logic [19:0] s_usec,
                         logic [31:0] n_sec, logic [19:0] n_usec);
    pending_q.push_back('{1'b0, seq, s_sec, s_usec, n_sec, n_usec});
  endtask

  task automatic add_drain();
    pending_q.push_back('{1'b1, 32'd0, 32'd0, 20'd0, 32'd0, 20'd0});
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run timeout.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, stats_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: offers the pending packets one word at a time and predicts each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stats_q.push_back(classify_packet(cur_pkt));
        n_accepted++;
        idle_left = idle_len(n_accepted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0 && pending_q[0].drain) begin
          // Hold the sender until the block has returned every outstanding word.
          if (stats_q.size() == 0) void'(pending_q.pop_front());
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_pkt = pending_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.seq_num   <= cur_pkt.seq_num;
          in_ch.sent_sec  <= cur_pkt.sent_sec;
          in_ch.sent_usec <= cur_pkt.sent_usec;
          in_ch.now_sec   <= cur_pkt.now_sec;
          in_ch.now_usec  <= cur_pkt.now_usec;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction and paces ready.
  always @(posedge clk_i) begin
    stats_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (stats_q.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual class %0d seq 0x%0h",
                   $time, out_ch.pkt_class, out_ch.highest_seq);
          n_errors++;
        end else begin
          want = stats_q.pop_front();
          check_field("pkt_class", want.cls, out_ch.pkt_class);
          check_field("latency_us", want.latency, out_ch.latency_us);
          check_field("recv_count", want.recv, out_ch.recv_count);
          check_field("dup_count", want.dup, out_ch.dup_count);
          check_field("unordered_count", want.unord, out_ch.unordered_count);
          check_field("min_latency_us", want.lat_min, out_ch.min_latency_us);
          check_field("max_latency_us", want.lat_max, out_ch.max_latency_us);
          check_field("highest_seq", want.top_seq, out_ch.highest_seq);
        end
      end
      // One long hold-off so that the block fills up and stalls its input.
      if (!hold_done && n_results >= HOLD_OFF_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len(n_results);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [31:0]     seq_base;
    logic [31:0]     seq;
    logic [31:0]     s_sec;
    logic [19:0]     s_usec;
    longint unsigned sent_t;
    longint unsigned now_t;
    longint          delta;
    int unsigned     kind;
    int unsigned     r;

    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.seq_num   = '0;
    in_ch.sent_sec  = '0;
    in_ch.sent_usec = '0;
    in_ch.now_sec   = '0;
    in_ch.now_usec  = '0;
    out_ch.ready    = 1'b0;
    seq_last        = '0;
    recv_total      = '0;
    dup_total       = '0;
    unord_total     = '0;
    lat_least       = '0;
    lat_greatest    = '0;

    // Directed opening: first packets with sequence zero, each class, latency extremes.
    add_pkt(32'd0, 32'd10, 20'd0, 32'd10, 20'd250);
    add_pkt(32'd0, 32'd20, 20'd500000, 32'd20, 20'd400000);
    add_pkt(32'd100, 32'd30, 20'd0, 32'd30, 20'd0);
    add_pkt(32'd100, 32'd30, 20'd0, 32'd30, 20'd1000);
    add_pkt(32'd50, 32'd40, 20'd0, 32'd40, 20'd7);
    add_pkt(32'd101, 32'd0, 20'd0, 32'hFFFF_FFFF, 20'hFFFFF);
    add_pkt(32'd3, 32'hFFFF_FFFF, 20'hFFFFF, 32'd0, 20'd0);
    add_pkt(32'd102, 32'd1, 20'd999999, 32'd2, 20'd0);
    add_pkt(32'd102, 32'd5, 20'hFFFFF, 32'd6, 20'd0);
    add_pkt(32'd1, 32'd7, 20'd0, 32'd7, 20'hFFFFF);
    add_pkt(32'd103, 32'hFFFF_FFFF, 20'd999999, 32'hFFFF_FFFF, 20'hFFFFF);
    add_pkt(32'd104, 32'd0, 20'd0, 32'd0, 20'd0);
    add_drain();

    // Random part: mostly a rising sequence with duplicates and late packets, some noise.
    seq_base = $urandom_range(32'h4000_0000, 32'h7FFF_0000);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        // Pause the sender once, then move the sequence into its upper half.
        add_drain();
        seq_base = $urandom_range(32'h8000_0000, 32'hC000_0000);
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        seq = seq_base - $urandom_range(0, seq_base);
        add_pkt(seq, $urandom,
                ($urandom_range(0, 1) != 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                            : 20'($urandom_range(0, 999999)),
                $urandom,
                ($urandom_range(0, 1) != 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                            : 20'($urandom_range(0, 999999)));
      end else begin
        if (kind < 68) begin
          seq_base = seq_base + $urandom_range(1, 4);
          seq      = seq_base;
        end else if (kind < 80) begin
          seq = seq_base;
        end else if (kind < 95) begin
          seq = seq_base - $urandom_range(1, 20);
        end else begin
          seq_base = seq_base + $urandom_range(5, 100000);
          seq      = seq_base;
        end
        // Reception time is the send time moved by a random latency, sometimes negative.
        s_sec  = $urandom_range(16, 32'hFFFF_FF00);
        s_usec = 20'($urandom_range(0, 999999));
        r      = $urandom_range(0, 99);
        if (r < 70) delta = longint'($urandom_range(0, 200000));
        else if (r < 85) delta = longint'($urandom_range(200000, 5000000));
        else if (r < 93) delta = -longint'($urandom_range(1, 2000000));
        else delta = 0;
        sent_t = 64'(s_sec) * 64'(pslm_pkg::USEC_PER_SEC) + 64'(s_usec);
        now_t  = sent_t + delta;
        add_pkt(seq, s_sec, s_usec, 32'(now_t / 64'(pslm_pkg::USEC_PER_SEC)),
                20'(now_t % 64'(pslm_pkg::USEC_PER_SEC)));
      end
    end

    // Directed close: sequence extremes, once the random part no longer needs room above.
    add_pkt(32'hFFFF_FFFF, 32'd100, 20'd0, 32'd100, 20'd10);
    add_pkt(32'hFFFF_FFFF, 32'd100, 20'd0, 32'd99, 20'd0);
    add_pkt(32'hFFFF_FFFE, 32'd200, 20'd5, 32'd200, 20'd5);
    add_pkt(32'd0, 32'd300, 20'd0, 32'd301, 20'd0);
    add_pkt(32'hFFFF_FFFF, 32'h8000_0000, 20'd0, 32'h8000_0001, 20'hFFFFF);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last word to be accepted and every prediction to be met.
    while (pending_q.size() != 0 || in_ch.valid || stats_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
